[rtl/core/gfs_pkg.sv]
// ----------------------------------------------------------------------------
// gfs_pkg
// Shared constants, types and helpers for the gradient focus statistics block.
// ----------------------------------------------------------------------------
package gfs_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int SUM_BITS   = 40;
  localparam int OUT_W      = 40;
  localparam int CNT_W      = 24;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int POS_W      = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int NUM_SUMS   = 6;
  localparam int NUM_CNTS   = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = NUM_SUMS * OUT_W + NUM_CNTS * CNT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [POS_W-1:0] MIN_W_EFF = POS_W'(2);
  localparam logic [POS_W-1:0] MAX_W_EFF = POS_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(MAX_HEIGHT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_CHANNEL_SELECT = 3'd1,
    CFG_OVER_LIMIT     = 3'd2,
    CFG_UNDER_LIMIT    = 3'd3,
    CFG_BOX_COL_FIRST  = 3'd4,
    CFG_BOX_COL_LAST   = 3'd5,
    CFG_BOX_ROW_FIRST  = 3'd6,
    CFG_BOX_ROW_LAST   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CH_ZERO  = 2'd0,
    CH_ONE   = 2'd1,
    CH_TWO   = 2'd2,
    CH_SPARE = 2'd3
  } chan_t;

  typedef struct packed {
    logic [POS_W-1:0] image_width;
    logic [1:0]       channel_select;
    logic [PIX_W-1:0] over_limit;
    logic [PIX_W-1:0] under_limit;
    logic [COL_W-1:0] box_col_first;
    logic [COL_W-1:0] box_col_last;
    logic [ROW_W-1:0] box_row_first;
    logic [ROW_W-1:0] box_row_last;
  } cfg_t;

  // One pixel's work as it leaves the position tracker.
  typedef struct packed {
    logic             wr;      // line store write of held pixel
    logic             stats;   // pixel contributes to sums and counts
    logic             in_box;
    logic             over;
    logic             under;
    logic             fe;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] p;
    logic [PIX_W-1:0] dh;
  } item_t;

  function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
                                                  logic [PIX_W:0] v);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {{(SUM_BITS - PIX_W){1'b0}}, v};
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_inc(logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(logic [PIX_W-1:0] a,
                                                logic [PIX_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

[rtl/core/gradient_focus_statistics.sv]
// ----------------------------------------------------------------------------
// gradient_focus_statistics
// Sum-of-absolute-differences focus measure over a raster stream.
//
//   channel   dir  payload
//   in_*      in   tdata: sample_zero, sample_one, sample_two; tlast: frame_end
//   out_*     out  tdata: six 40-bit sums, three 24-bit counts (one per frame)
//   cfg_*     in   index 0..7, data up to 13 bits
//
// One pixel per clock while in_tready is high; the result register loads as
// the frame-end pixel leaves stage one, once the registered line store read returns.
// Synchronous active-low reset; the line store is not cleared.
// in_tready drops only while a frame-end pixel waits on a full, stalled
// result register; otherwise pixels flow on while a result waits.
// ----------------------------------------------------------------------------
module gradient_focus_statistics
  import gfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_zero, sample_one, sample_two
  input  logic                  in_tlast,   // frame_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // image_overall, image_horizontal, image_vertical, box_overall,
  // box_horizontal, box_vertical, over_count, under_count, sample_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg_r, cfg_nxt;
  logic             accept;
  item_t            item;
  logic             rd_en, wr_en;
  logic [COL_W-1:0] rd_addr, wr_addr;
  logic [PIX_W-1:0] rd_data, wr_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:    cfg_nxt.image_width    = cfg_data[POS_W-1:0];
        CFG_CHANNEL_SELECT: cfg_nxt.channel_select = cfg_data[1:0];
        CFG_OVER_LIMIT:     cfg_nxt.over_limit     = cfg_data[PIX_W-1:0];
        CFG_UNDER_LIMIT:    cfg_nxt.under_limit    = cfg_data[PIX_W-1:0];
        CFG_BOX_COL_FIRST:  cfg_nxt.box_col_first  = cfg_data[COL_W-1:0];
        CFG_BOX_COL_LAST:   cfg_nxt.box_col_last   = cfg_data[COL_W-1:0];
        CFG_BOX_ROW_FIRST:  cfg_nxt.box_row_first  = cfg_data[ROW_W-1:0];
        CFG_BOX_ROW_LAST:   cfg_nxt.box_row_last   = cfg_data[ROW_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= POS_W'(4096);
      cfg_r.channel_select <= CH_ONE;
      cfg_r.over_limit     <= PIX_W'(230);
      cfg_r.under_limit    <= PIX_W'(25);
      cfg_r.box_col_first  <= '0;
      cfg_r.box_col_last   <= '0;
      cfg_r.box_row_first  <= '0;
      cfg_r.box_row_last   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .sample_zero (in_tdata[7:0]),
    .sample_one  (in_tdata[15:8]),
    .sample_two  (in_tdata[23:16]),
    .frame_end   (in_tlast),
    .item        (item),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  gfs_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  gfs_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

[rtl/core/gfs_line_ram.sv]
// ----------------------------------------------------------------------------
// gfs_line_ram
// Simple dual-port line store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gfs_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/gfs_front.sv]
// ----------------------------------------------------------------------------
// gfs_front
// Raster position tracking, channel pick, held pixel and per-pixel flags.
// ----------------------------------------------------------------------------
module gfs_front
  import gfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             accept,
  input  logic [PIX_W-1:0] sample_zero,
  input  logic [PIX_W-1:0] sample_one,
  input  logic [PIX_W-1:0] sample_two,
  input  logic             frame_end,
  output item_t            item,
  output logic             rd_en,
  output logic [COL_W-1:0] rd_addr
);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] held_r, held_nxt;

  logic [POS_W-1:0] w_eff;
  logic [PIX_W-1:0] s;
  logic [POS_W-1:0] col_a, col_b;
  logic [ROW_W-1:0] row_a;
  logic [COL_W-1:0] c;

  always_comb begin
    if (cfg.image_width < MIN_W_EFF) begin
      w_eff = MIN_W_EFF;
    end else if (cfg.image_width > MAX_W_EFF) begin
      w_eff = MAX_W_EFF;
    end else begin
      w_eff = cfg.image_width;
    end

    case (chan_t'(cfg.channel_select))
      CH_ONE:  s = sample_one;
      CH_TWO:  s = sample_two;
      default: s = sample_zero;
    endcase

    // width shrunk mid-row: pixel starts the next row
    if (col_r >= w_eff) begin
      col_a = '0;
      row_a = (row_r == ROW_MAX) ? row_r : row_r + 1'b1;
    end else begin
      col_a = col_r;
      row_a = row_r;
    end

    c = col_a[COL_W-1:0] - 1'b1;

    item.wr     = (col_a != '0);
    item.stats  = (col_a != '0) && (row_a != '0);
    item.in_box = (c >= cfg.box_col_first) && (c <= cfg.box_col_last) &&
                  (row_a >= cfg.box_row_first) && (row_a <= cfg.box_row_last);
    item.over   = (held_r >= cfg.over_limit);
    item.under  = (held_r <= cfg.under_limit);
    item.fe     = frame_end;
    item.addr   = c;
    item.p      = held_r;
    item.dh     = abs_diff(held_r, s);

    rd_en   = accept && item.stats;
    rd_addr = c;

    col_b    = col_a + 1'b1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    if (accept) begin
      held_nxt = s;
      if (col_b >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_a == ROW_MAX) ? row_a : row_a + 1'b1;
      end else begin
        col_nxt = col_b;
        row_nxt = row_a;
      end
      if (frame_end) begin
        held_nxt = '0;
        col_nxt  = '0;
        row_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

[rtl/core/gfs_accum.sv]
// ----------------------------------------------------------------------------
// gfs_accum
// Line store read-modify-write stage, saturating sums and counts, result reg.
// ----------------------------------------------------------------------------
module gfs_accum
  import gfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  item_t                 item,
  input  logic                  rd_en,
  input  logic [COL_W-1:0]      rd_addr,
  input  logic [PIX_W-1:0]      rd_data,
  output logic                  wr_en,
  output logic [COL_W-1:0]      wr_addr,
  output logic [PIX_W-1:0]      wr_data,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  item_t            s1_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic             stall, fire;

  logic [SUM_BITS-1:0] acc_r   [NUM_SUMS];
  logic [SUM_BITS-1:0] acc_nxt [NUM_SUMS];
  logic [CNT_W-1:0]    cnt_r   [NUM_CNTS];
  logic [CNT_W-1:0]    cnt_nxt [NUM_CNTS];

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] dv;
  logic [PIX_W:0]   dsum;

  assign stall    = s1_valid_r && s1_r.fe && out_valid_r && !out_ready;
  assign fire     = s1_valid_r && !stall;
  assign in_ready = !stall;

  assign wr_en   = fire && s1_r.wr;
  assign wr_addr = s1_r.addr;
  assign wr_data = s1_r.p;

  always_comb begin
    above = fwd_r ? fwd_data_r : rd_data;
    dv    = abs_diff(s1_r.p, above);
    dsum  = {1'b0, dv} + {1'b0, s1_r.dh};

    for (int k = 0; k < NUM_SUMS; k++) begin
      acc_nxt[k] = acc_r[k];
    end
    for (int k = 0; k < NUM_CNTS; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    if (s1_r.stats) begin
      acc_nxt[0] = sat_add(acc_r[0], dsum);
      acc_nxt[1] = sat_add(acc_r[1], {1'b0, s1_r.dh});
      acc_nxt[2] = sat_add(acc_r[2], {1'b0, dv});
      if (s1_r.in_box) begin
        acc_nxt[3] = sat_add(acc_r[3], dsum);
        acc_nxt[4] = sat_add(acc_r[4], {1'b0, s1_r.dh});
        acc_nxt[5] = sat_add(acc_r[5], {1'b0, dv});
      end
      if (s1_r.over) begin
        cnt_nxt[0] = cnt_inc(cnt_r[0]);
      end
      if (s1_r.under) begin
        cnt_nxt[1] = cnt_inc(cnt_r[1]);
      end
      cnt_nxt[2] = cnt_inc(cnt_r[2]);
    end

    s1_valid_nxt = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

    if (fire && s1_r.fe) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_SUMS; k++) begin
        acc_r[k] <= '0;
      end
      for (int k = 0; k < NUM_CNTS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        for (int k = 0; k < NUM_SUMS; k++) begin
          acc_r[k] <= s1_r.fe ? '0 : acc_nxt[k];
        end
        for (int k = 0; k < NUM_CNTS; k++) begin
          cnt_r[k] <= s1_r.fe ? '0 : cnt_nxt[k];
        end
      end
    end
  end

  // payload, bypass of a write landing on the entry being read, and result load
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r       <= item;
      fwd_r      <= wr_en && rd_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
    if (fire && s1_r.fe) begin
      for (int k = 0; k < NUM_SUMS; k++) begin
        out_data_r[k*OUT_W +: OUT_W] <= OUT_W'(acc_nxt[k]);
      end
      for (int k = 0; k < NUM_CNTS; k++) begin
        out_data_r[NUM_SUMS*OUT_W + k*CNT_W +: CNT_W] <= cnt_nxt[k];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fe_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_r.fe |=> out_valid_r)
    else $error("frame end transaction produced no result");

  a_fe_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_r.fe |=> cnt_r[2] == '0 && acc_r[0] == '0)
    else $error("statistics not cleared after frame end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> s1_valid_r && !$past(accept))
    else $error("stage one lost during result stall");

  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept && wr_en && rd_en && wr_addr == rd_addr |=> fwd_r)
    else $error("line store hazard not bypassed");

endmodule
